### src/tsm_pkg.sv
`timescale 1ns / 1ps

package tsm_pkg;

  // input mode codes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_REL  = 2'd1;
  localparam logic [1:0] MODE_ABS  = 2'd2;

  localparam int TARGET_W   = 16;
  localparam int OUT_POS_W  = 16;
  localparam int HP_W       = 16;
  localparam int BO_W       = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_HALF     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_HALF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_STEPS = 2'd2;

  localparam logic [HP_W-1:0] STEP_HALF_RST     = 16'd1000;
  localparam logic [HP_W-1:0] BACKOFF_HALF_RST  = 16'd1500;
  localparam logic [BO_W-1:0] BACKOFF_STEPS_RST = 10'd35;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_REL,
    CMD_ABS,
    CMD_NONE
  } cmd_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_Y_MOVE,
    PH_Y_BACK,
    PH_X_MOVE,
    PH_X_BACK
  } phase_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic signed [TARGET_W-1:0] target_x;
    logic signed [TARGET_W-1:0] target_y;
    logic                  limit_x_n;
    logic                  limit_y_n;
  } cmd_t;

endpackage

### src/tsm_front.sv
`timescale 1ns / 1ps

module tsm_front (
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           mode,
  input  logic signed [tsm_pkg::TARGET_W-1:0]  target_x,
  input  logic signed [tsm_pkg::TARGET_W-1:0]  target_y,
  input  logic                                 limit_x_n,
  input  logic                                 limit_y_n,
  output logic                                 q_valid,
  input  logic                                 q_ready,
  output tsm_pkg::cmd_t                        q_item
);

  tsm_pkg::cmd_kind_t kind;

  always_comb begin
    case (mode)
      tsm_pkg::MODE_TICK: kind = tsm_pkg::CMD_TICK;
      tsm_pkg::MODE_REL:  kind = tsm_pkg::CMD_REL;
      tsm_pkg::MODE_ABS:  kind = tsm_pkg::CMD_ABS;
      default:            kind = tsm_pkg::CMD_NONE;
    endcase
  end

  assign q_item.kind      = kind;
  assign q_item.target_x  = target_x;
  assign q_item.target_y  = target_y;
  assign q_item.limit_x_n = limit_x_n;
  assign q_item.limit_y_n = limit_y_n;

  assign q_valid  = in_valid;
  assign in_ready = q_ready;

endmodule

### src/tsm_queue.sv
`timescale 1ns / 1ps

module tsm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tsm_pkg::cmd_t push_item,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tsm_pkg::cmd_t pop_item
);

  localparam logic [tsm_pkg::QPTR_W-1:0] LAST = tsm_pkg::QPTR_W'(tsm_pkg::QUEUE_DEPTH - 1);
  localparam logic [tsm_pkg::QPTR_W:0]   FULL = (tsm_pkg::QPTR_W + 1)'(tsm_pkg::QUEUE_DEPTH);

  tsm_pkg::cmd_t slots [tsm_pkg::QUEUE_DEPTH];
  logic [tsm_pkg::QPTR_W-1:0] wptr;
  logic [tsm_pkg::QPTR_W-1:0] rptr;
  logic [tsm_pkg::QPTR_W:0]   count;
  logic push;
  logic pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/tsm_back.sv
`timescale 1ns / 1ps

module tsm_back #(
  parameter int POS_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  tsm_pkg::cmd_t                         q_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tsm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tsm_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  step_x,
  output logic                                  step_y,
  output logic                                  dir_x,
  output logic                                  dir_y,
  output logic [tsm_pkg::OUT_POS_W-1:0]         pos_x,
  output logic [tsm_pkg::OUT_POS_W-1:0]         pos_y,
  output logic                                  busy_res,
  output logic                                  move_done,
  output logic                                  limit_x_hit,
  output logic                                  limit_y_hit,
  output logic                                  cmd_rejected
);

  // delta / step count width: target minus position without overflow
  localparam int DW = ((POS_WIDTH > tsm_pkg::TARGET_W) ? POS_WIDTH : tsm_pkg::TARGET_W) + 1;
  // saturating add width: position plus back-off count
  localparam int SW = ((POS_WIDTH > tsm_pkg::BO_W) ? POS_WIDTH : tsm_pkg::BO_W) + 2;
  localparam logic signed [SW-1:0] POS_MAX =
    {{(SW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] POS_MIN = ~POS_MAX;
  localparam logic signed [SW-1:0] ONE_P = SW'(1);
  localparam logic signed [SW-1:0] ONE_N = -ONE_P;

  function automatic logic signed [POS_WIDTH-1:0] sat_add(
    input logic signed [POS_WIDTH-1:0] p,
    input logic signed [SW-1:0]        d
  );
    logic signed [SW-1:0] s;
    s = SW'(p) + d;
    if (s > POS_MAX) begin
      s = POS_MAX;
    end else if (s < POS_MIN) begin
      s = POS_MIN;
    end
    return POS_WIDTH'(s);
  endfunction

  function automatic logic [DW-1:0] magnitude(input logic signed [DW-1:0] d);
    logic [DW-1:0] m;
    m = d[DW-1] ? DW'(-d) : DW'(d);
    return m;
  endfunction

  // configuration
  logic [tsm_pkg::HP_W-1:0] step_half_period;
  logic [tsm_pkg::HP_W-1:0] backoff_half_period;
  logic [tsm_pkg::BO_W-1:0] backoff_steps;

  // move state
  tsm_pkg::phase_t               phase, phase_next;
  logic signed [POS_WIDTH-1:0]   position_x, position_x_next;
  logic signed [POS_WIDTH-1:0]   position_y, position_y_next;
  logic signed [DW-1:0]          pending_x_delta, pending_x_delta_next;
  logic [DW-1:0]                 steps_remaining, steps_remaining_next;
  logic [tsm_pkg::HP_W-1:0]      half_period_count, half_period_count_next;
  logic                          pulse_level, pulse_level_next;
  logic [1:0]                    direction_bits, direction_bits_next;

  logic take;
  logic done, hit_x, hit_y, rejected;

  logic signed [DW-1:0]          dx, dy;
  logic                          is_y, backing;
  logic [tsm_pkg::HP_W-1:0]      hp_sel, hp_eff;
  logic [tsm_pkg::HP_W:0]        cnt_inc;
  logic [DW-1:0]                 steps_dec;
  logic signed [POS_WIDTH-1:0]   cur_pos, pos_one, pos_back;
  logic                          pos_dir, limit_hit;
  logic signed [SW-1:0]          bo_ext;
  logic                          x_active, y_active;

  assign cfg_ready = 1'b1;
  assign q_ready   = !out_valid || out_ready;
  assign take      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_half_period    <= tsm_pkg::STEP_HALF_RST;
      backoff_half_period <= tsm_pkg::BACKOFF_HALF_RST;
      backoff_steps       <= tsm_pkg::BACKOFF_STEPS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsm_pkg::CFG_STEP_HALF:     step_half_period    <= cfg_data;
        tsm_pkg::CFG_BACKOFF_HALF:  backoff_half_period <= cfg_data;
        tsm_pkg::CFG_BACKOFF_STEPS: backoff_steps       <= cfg_data[tsm_pkg::BO_W-1:0];
        default: ;
      endcase
    end
  end

  // shared datapath terms
  always_comb begin
    dx = DW'(signed'(q_item.target_x));
    dy = DW'(signed'(q_item.target_y));
    if (q_item.kind == tsm_pkg::CMD_ABS) begin
      dx = dx - DW'(position_x);
      dy = dy - DW'(position_y);
    end
    is_y      = (phase == tsm_pkg::PH_Y_MOVE) || (phase == tsm_pkg::PH_Y_BACK);
    backing   = (phase == tsm_pkg::PH_Y_BACK) || (phase == tsm_pkg::PH_X_BACK);
    hp_sel    = backing ? backoff_half_period : step_half_period;
    hp_eff    = (hp_sel == '0) ? tsm_pkg::HP_W'(1) : hp_sel;
    cnt_inc   = {1'b0, half_period_count} + 1'b1;
    steps_dec = (steps_remaining != '0) ? steps_remaining - 1'b1 : '0;
    cur_pos   = is_y ? position_y : position_x;
    pos_dir   = is_y ? direction_bits[1] : direction_bits[0];
    limit_hit = is_y ? !q_item.limit_y_n : !q_item.limit_x_n;
    bo_ext    = SW'(signed'({1'b0, backoff_steps}));
    pos_one   = sat_add(cur_pos, pos_dir ? ONE_P : ONE_N);
    pos_back  = sat_add(pos_one, pos_dir ? -bo_ext : bo_ext);
  end

  // next state
  always_comb begin
    phase_next             = phase;
    position_x_next        = position_x;
    position_y_next        = position_y;
    pending_x_delta_next   = pending_x_delta;
    steps_remaining_next   = steps_remaining;
    half_period_count_next = half_period_count;
    pulse_level_next       = pulse_level;
    direction_bits_next    = direction_bits;
    done     = 1'b0;
    hit_x    = 1'b0;
    hit_y    = 1'b0;
    rejected = 1'b0;

    case (q_item.kind)
      tsm_pkg::CMD_REL, tsm_pkg::CMD_ABS: begin
        if (phase != tsm_pkg::PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          pending_x_delta_next = dx;
          if (dy != '0) begin
            direction_bits_next[1] = !dy[DW-1];
            steps_remaining_next   = magnitude(dy);
            phase_next             = tsm_pkg::PH_Y_MOVE;
            half_period_count_next = '0;
            pulse_level_next       = 1'b1;
          end else if (dx != '0) begin
            direction_bits_next[0] = !dx[DW-1];
            steps_remaining_next   = magnitude(dx);
            phase_next             = tsm_pkg::PH_X_MOVE;
            half_period_count_next = '0;
            pulse_level_next       = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
      end
      tsm_pkg::CMD_TICK: begin
        if (phase != tsm_pkg::PH_IDLE) begin
          if (cnt_inc >= {1'b0, hp_eff}) begin
            half_period_count_next = '0;
            if (pulse_level) begin
              pulse_level_next = 1'b0;
            end else begin
              logic end_axis;
              end_axis = 1'b0;
              steps_remaining_next = steps_dec;
              if (!backing) begin
                if (is_y) begin
                  position_y_next = pos_one;
                end else begin
                  position_x_next = pos_one;
                end
                if (limit_hit) begin
                  hit_y = is_y;
                  hit_x = !is_y;
                  if (backoff_steps == '0) begin
                    end_axis = 1'b1;
                  end else begin
                    direction_bits_next = direction_bits ^ (is_y ? 2'b10 : 2'b01);
                    if (is_y) begin
                      position_y_next = pos_back;
                    end else begin
                      position_x_next = pos_back;
                    end
                    steps_remaining_next = DW'(backoff_steps);
                    phase_next = is_y ? tsm_pkg::PH_Y_BACK : tsm_pkg::PH_X_BACK;
                    pulse_level_next = 1'b1;
                  end
                end else if (steps_dec == '0) begin
                  end_axis = 1'b1;
                end else begin
                  pulse_level_next = 1'b1;
                end
              end else if (steps_dec == '0) begin
                end_axis = 1'b1;
              end else begin
                pulse_level_next = 1'b1;
              end

              if (end_axis) begin
                pulse_level_next       = 1'b0;
                half_period_count_next = '0;
                steps_remaining_next   = '0;
                // Y finished: chain into the X leg if it has any length
                if (is_y && pending_x_delta != '0) begin
                  direction_bits_next[0] = !pending_x_delta[DW-1];
                  steps_remaining_next   = magnitude(pending_x_delta);
                  phase_next             = tsm_pkg::PH_X_MOVE;
                  pulse_level_next       = 1'b1;
                end else begin
                  phase_next = tsm_pkg::PH_IDLE;
                  done       = 1'b1;
                end
              end
            end
          end else begin
            half_period_count_next = cnt_inc[tsm_pkg::HP_W-1:0];
          end
        end
      end
      default: ;
    endcase

    x_active = (phase_next == tsm_pkg::PH_X_MOVE) || (phase_next == tsm_pkg::PH_X_BACK);
    y_active = (phase_next == tsm_pkg::PH_Y_MOVE) || (phase_next == tsm_pkg::PH_Y_BACK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= tsm_pkg::PH_IDLE;
      position_x        <= '0;
      position_y        <= '0;
      pending_x_delta   <= '0;
      steps_remaining   <= '0;
      half_period_count <= '0;
      pulse_level       <= 1'b0;
      direction_bits    <= '0;
    end else if (take) begin
      phase             <= phase_next;
      position_x        <= position_x_next;
      position_y        <= position_y_next;
      pending_x_delta   <= pending_x_delta_next;
      steps_remaining   <= steps_remaining_next;
      half_period_count <= half_period_count_next;
      pulse_level       <= pulse_level_next;
      direction_bits    <= direction_bits_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      step_x       <= x_active && pulse_level_next;
      step_y       <= y_active && pulse_level_next;
      dir_x        <= direction_bits_next[0];
      dir_y        <= direction_bits_next[1];
      pos_x        <= tsm_pkg::OUT_POS_W'(unsigned'(position_x_next));
      pos_y        <= tsm_pkg::OUT_POS_W'(unsigned'(position_y_next));
      busy_res     <= (phase_next != tsm_pkg::PH_IDLE);
      move_done    <= done;
      limit_x_hit  <= hit_x;
      limit_y_hit  <= hit_y;
      cmd_rejected <= rejected;
    end
  end

  a_busy_has_steps: assert property (@(posedge clk) disable iff (rst)
    phase != tsm_pkg::PH_IDLE |-> steps_remaining != '0)
    else $error("active axis with no steps left");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == tsm_pkg::PH_IDLE |-> !pulse_level && half_period_count == '0)
    else $error("idle with pulse or timer running");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && move_done |-> !busy_res)
    else $error("move_done while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && cmd_rejected |-> busy_res && !move_done)
    else $error("rejected command without a move in progress");

endmodule

### src/two_axis_step_mover_with_limit_backoff.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    mode, target_x, target_y, limit_x_n, limit_y_n
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (0 step, 1 back-off half, 2 back-off steps)
// out       out_valid / out_ready  step_x/y, dir_x/y, pos_x/y, busy_res, move_done,
//                                  limit_x_hit, limit_y_hit, cmd_rejected
//
// One request per cycle while out_ready stays high; each request's state update is registered
// in the back-end sequencer; out_valid follows the in accept via the queue, then the out reg.
// Reset (rst, synchronous) idles both axes, zeroes positions and loads register defaults.
// out_ready low holds the output register; the two-entry queue then fills and in_ready
// drops. cfg_ready is always high.
module two_axis_step_mover_with_limit_backoff #(
  parameter int POS_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           mode,
  input  logic signed [tsm_pkg::TARGET_W-1:0]  target_x,
  input  logic signed [tsm_pkg::TARGET_W-1:0]  target_y,
  input  logic                                 limit_x_n,
  input  logic                                 limit_y_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tsm_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 step_x,
  output logic                                 step_y,
  output logic                                 dir_x,
  output logic                                 dir_y,
  output logic signed [tsm_pkg::OUT_POS_W-1:0] pos_x,
  output logic signed [tsm_pkg::OUT_POS_W-1:0] pos_y,
  output logic                                 busy_res,
  output logic                                 move_done,
  output logic                                 limit_x_hit,
  output logic                                 limit_y_hit,
  output logic                                 cmd_rejected
);

  logic          fq_valid, fq_ready;
  tsm_pkg::cmd_t fq_item;
  logic          qb_valid, qb_ready;
  tsm_pkg::cmd_t qb_item;
  logic [tsm_pkg::OUT_POS_W-1:0] pos_x_u, pos_y_u;

  tsm_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .target_x  (target_x),
    .target_y  (target_y),
    .limit_x_n (limit_x_n),
    .limit_y_n (limit_y_n),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  tsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  tsm_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (qb_valid),
    .q_ready      (qb_ready),
    .q_item       (qb_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .step_x       (step_x),
    .step_y       (step_y),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .pos_x        (pos_x_u),
    .pos_y        (pos_y_u),
    .busy_res     (busy_res),
    .move_done    (move_done),
    .limit_x_hit  (limit_x_hit),
    .limit_y_hit  (limit_y_hit),
    .cmd_rejected (cmd_rejected)
  );

  assign pos_x = signed'(pos_x_u);
  assign pos_y = signed'(pos_y_u);

endmodule
